// File: rtl/sall_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sall_pkg
// Shared types and constants of the sorted linked list table: request and
// result items, request and status codes, store control bundle.
// ----------------------------------------------------------------------------
package sall_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int VALUE_W         = 32;
    localparam int POS_W           = 7;
    localparam int OUT_SLOT_W      = 6;
    localparam int LEN_W           = 6;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_DEL_VALUE = 2'd1,
        REQ_DEL_POS   = 2'd2,
        REQ_CLEAR     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_DUP       = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t                  req_type;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } req_item_t;

    typedef struct packed {
        status_t                 status;
        logic [OUT_SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]        length;
    } rsp_item_t;

    typedef struct packed {
        logic rd_en;
        logic node_we;
        logic value_we;
    } store_ctrl_t;

endpackage

// File: rtl/sall_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sall_req_if
// Request channel: valid/ready handshake carrying one list request.
// ----------------------------------------------------------------------------
interface sall_req_if;

    logic                 valid;
    logic                 ready;
    sall_pkg::req_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/sall_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sall_rsp_if
// Result channel: valid/ready handshake carrying status, slot and length.
// ----------------------------------------------------------------------------
interface sall_rsp_if;

    logic                 valid;
    logic                 ready;
    sall_pkg::rsp_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/sorted_array_linked_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_linked_list
// Ascending list of distinct signed values kept in a slot table with links.
// Inserts walk the list and then scan for a free slot; deletes walk the
// list. Walk and scan read one list link or one slot at a time, set by
// the one read port of the slot store. Clear sweeps every slot of the
// table. One request in flight at a time. After reset a clearing pass
// over every slot runs before requests are taken.
// ----------------------------------------------------------------------------
module sorted_array_linked_list #(
    parameter int TABLE_SLOTS = sall_pkg::TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sall_req_if.sink    req,
    sall_rsp_if.source  rsp
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CMP_W  = (SLOT_W > sall_pkg::POS_W) ? SLOT_W : sall_pkg::POS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] HEAD_SLOT = '0;

    typedef enum logic [8:0] {
        ST_INIT      = 9'b000000001,
        ST_IDLE      = 9'b000000010,
        ST_HEAD      = 9'b000000100,
        ST_WALK      = 9'b000001000,
        ST_DECIDE    = 9'b000010000,
        ST_FREE_SLOT = 9'b000100000,
        ST_SCAN      = 9'b001000000,
        ST_LINK      = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t                              state_reg, state_next;
    sall_pkg::req_type_t                 req_type_reg, req_type_next;
    logic signed [sall_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [sall_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [sall_pkg::POS_W-1:0]          step_reg, step_next;
    logic [SLOT_W-1:0]                   prev_reg, prev_next;
    logic [SLOT_W-1:0]                   cur_reg, cur_next;
    logic [SLOT_W-1:0]                   nxt_reg, nxt_next;
    logic                                match_reg, match_next;
    logic [SLOT_W-1:0]                   scan_reg, scan_next;
    logic [SLOT_W-1:0]                   sweep_reg, sweep_next;
    logic                                clear_pending_reg, clear_pending_next;
    logic [SLOT_W-1:0]                   count_reg, count_next;
    sall_pkg::status_t                   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]                   res_slot_reg, res_slot_next;
    logic                                out_valid_reg, out_valid_next;
    sall_pkg::rsp_item_t                 out_item_reg, out_item_next;

    sall_pkg::store_ctrl_t               store_ctrl;
    logic [SLOT_W-1:0]                   rd_addr;
    logic [SLOT_W-1:0]                   wr_addr;
    logic                                wr_free;
    logic [SLOT_W-1:0]                   wr_link;
    logic                                rd_free;
    logic [SLOT_W-1:0]                   rd_link;
    logic signed [sall_pkg::VALUE_W-1:0] rd_value;

    sall_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .clk      (clk),
        .ctrl     (store_ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_free  (wr_free),
        .wr_link  (wr_link),
        .wr_value (key_reg),
        .rd_free  (rd_free),
        .rd_link  (rd_link),
        .rd_value (rd_value)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    always_comb
    begin
        state_next         = state_reg;
        req_type_next      = req_type_reg;
        key_next           = key_reg;
        pos_next           = pos_reg;
        step_next          = step_reg;
        prev_next          = prev_reg;
        cur_next           = cur_reg;
        nxt_next           = nxt_reg;
        match_next         = match_reg;
        scan_next          = scan_reg;
        sweep_next         = sweep_reg;
        clear_pending_next = clear_pending_reg;
        count_next         = count_reg;
        res_status_next    = res_status_reg;
        res_slot_next      = res_slot_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        out_item_next      = out_item_reg;
        store_ctrl         = '0;
        rd_addr            = HEAD_SLOT;
        wr_addr            = HEAD_SLOT;
        wr_free            = 1'b0;
        wr_link            = HEAD_SLOT;

        unique case (state_reg)
            ST_INIT:
            begin
                store_ctrl.node_we = 1'b1;
                wr_addr            = sweep_reg;
                wr_free            = (sweep_reg != HEAD_SLOT);
                if (sweep_reg == LAST_SLOT)
                begin
                    count_next = '0;
                    if (clear_pending_reg)
                    begin
                        clear_pending_next = 1'b0;
                        res_status_next    = sall_pkg::STATUS_DONE;
                        res_slot_next      = HEAD_SLOT;
                        state_next         = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + SLOT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.payload.req_type;
                    key_next      = req.payload.value;
                    pos_next      = req.payload.position;
                    prev_next     = HEAD_SLOT;
                    step_next     = sall_pkg::POS_W'(1);
                    unique case (req.payload.req_type)
                        sall_pkg::REQ_INSERT,
                        sall_pkg::REQ_DEL_VALUE:
                        begin
                            store_ctrl.rd_en = 1'b1;
                            state_next       = ST_HEAD;
                        end
                        sall_pkg::REQ_DEL_POS:
                        begin
                            if (req.payload.position == '0 ||
                                CMP_W'(req.payload.position) > CMP_W'(count_reg))
                            begin
                                res_status_next = sall_pkg::STATUS_NOT_FOUND;
                                res_slot_next   = HEAD_SLOT;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                store_ctrl.rd_en = 1'b1;
                                state_next       = ST_HEAD;
                            end
                        end
                        sall_pkg::REQ_CLEAR:
                        begin
                            sweep_next         = HEAD_SLOT;
                            clear_pending_next = 1'b1;
                            state_next         = ST_INIT;
                        end
                    endcase
                end
            end

            ST_HEAD:
            begin
                cur_next   = rd_link;
                match_next = 1'b0;
                if (rd_link == HEAD_SLOT)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    store_ctrl.rd_en = 1'b1;
                    rd_addr          = rd_link;
                    state_next       = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (req_type_reg == sall_pkg::REQ_DEL_POS)
                begin
                    if (step_reg == pos_reg)
                    begin
                        match_next = 1'b1;
                        nxt_next   = rd_link;
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        cur_next  = rd_link;
                        step_next = step_reg + sall_pkg::POS_W'(1);
                        if (rd_link == HEAD_SLOT)
                        begin
                            state_next = ST_DECIDE;
                        end
                        else
                        begin
                            store_ctrl.rd_en = 1'b1;
                            rd_addr          = rd_link;
                        end
                    end
                end
                else if (rd_value < key_reg)
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    if (rd_link == HEAD_SLOT)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        store_ctrl.rd_en = 1'b1;
                        rd_addr          = rd_link;
                    end
                end
                else
                begin
                    match_next = (rd_value == key_reg);
                    nxt_next   = rd_link;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                res_slot_next = HEAD_SLOT;
                if (req_type_reg == sall_pkg::REQ_INSERT)
                begin
                    if (match_reg)
                    begin
                        res_status_next = sall_pkg::STATUS_DUP;
                        state_next      = ST_DONE;
                    end
                    else if (count_reg == LAST_SLOT)
                    begin
                        res_status_next = sall_pkg::STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        store_ctrl.rd_en = 1'b1;
                        rd_addr          = SLOT_W'(1);
                        scan_next        = SLOT_W'(1);
                        state_next       = ST_SCAN;
                    end
                end
                else if (match_reg)
                begin
                    store_ctrl.node_we = 1'b1;
                    wr_addr            = prev_reg;
                    wr_link            = nxt_reg;
                    count_next         = count_reg - SLOT_W'(1);
                    res_slot_next      = cur_reg;
                    state_next         = ST_FREE_SLOT;
                end
                else
                begin
                    res_status_next = sall_pkg::STATUS_NOT_FOUND;
                    state_next      = ST_DONE;
                end
            end

            ST_FREE_SLOT:
            begin
                store_ctrl.node_we = 1'b1;
                wr_addr            = cur_reg;
                wr_free            = 1'b1;
                res_status_next    = sall_pkg::STATUS_DONE;
                state_next         = ST_DONE;
            end

            ST_SCAN:
            begin
                if (rd_free)
                begin
                    store_ctrl.node_we  = 1'b1;
                    store_ctrl.value_we = 1'b1;
                    wr_addr             = scan_reg;
                    wr_link             = cur_reg;
                    count_next          = count_reg + SLOT_W'(1);
                    res_slot_next       = scan_reg;
                    state_next          = ST_LINK;
                end
                else
                begin
                    store_ctrl.rd_en = 1'b1;
                    rd_addr          = scan_reg + SLOT_W'(1);
                    scan_next        = scan_reg + SLOT_W'(1);
                end
            end

            ST_LINK:
            begin
                store_ctrl.node_we = 1'b1;
                wr_addr            = prev_reg;
                wr_link            = scan_reg;
                res_status_next    = sall_pkg::STATUS_DONE;
                state_next         = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.status = res_status_reg;
                    out_item_next.slot   = sall_pkg::OUT_SLOT_W'(res_slot_reg);
                    out_item_next.length = sall_pkg::LEN_W'(count_reg);
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            sweep_reg         <= '0;
            clear_pending_reg <= 1'b0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sweep_reg         <= sweep_next;
            clear_pending_reg <= clear_pending_next;
            count_reg         <= count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        match_reg      <= match_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_item_reg   <= out_item_next;
    end

    // free scan only starts when a slot is known to be free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != LAST_SLOT))
    else $error("free scan with a full table");

    // store is never read and written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        store_ctrl.node_we |-> !store_ctrl.rd_en)
    else $error("store read overlaps a write");

    // a successful delete has already dropped the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE_SLOT) |-> (count_reg == $past(count_reg) - SLOT_W'(1)))
    else $error("delete did not decrement the count");

    // finishing a request always presents a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || rsp.ready)) |=> rsp.valid)
    else $error("finished request produced no result");

endmodule

// File: rtl/sall_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sall_store
// Slot storage: node memory holding free mark and next link per slot, and
// value memory. One write port, one shared read address, registered read.
// ----------------------------------------------------------------------------
module sall_store #(
    parameter int TABLE_SLOTS = sall_pkg::TABLE_SLOTS_DEF
) (
    input  logic                                 clk,
    input  sall_pkg::store_ctrl_t                ctrl,
    input  logic [$clog2(TABLE_SLOTS)-1:0]       rd_addr,
    input  logic [$clog2(TABLE_SLOTS)-1:0]       wr_addr,
    input  logic                                 wr_free,
    input  logic [$clog2(TABLE_SLOTS)-1:0]       wr_link,
    input  logic signed [sall_pkg::VALUE_W-1:0]  wr_value,
    output logic                                 rd_free,
    output logic [$clog2(TABLE_SLOTS)-1:0]       rd_link,
    output logic signed [sall_pkg::VALUE_W-1:0]  rd_value
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic [SLOT_W:0]                     node_mem  [TABLE_SLOTS];
    logic signed [sall_pkg::VALUE_W-1:0] value_mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (ctrl.node_we)
        begin
            node_mem[wr_addr] <= {wr_free, wr_link};
        end
        if (ctrl.rd_en)
        begin
            {rd_free, rd_link} <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.value_we)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        if (ctrl.rd_en)
        begin
            rd_value <= value_mem[rd_addr];
        end
    end

endmodule

// File: tb/sorted_array_linked_list_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_linked_list_test
// Self-checking bench for the sorted list table. A scoreboard keeps its own
// copy of the slot table, links and free marks, predicts status, slot and
// length for every accepted request, and compares each result in order.
// Stimulus opens with corner cases (empty list, extreme values, duplicates,
// bad positions, clear), then runs random fill, drain and mixed episodes.
// Both handshake sides insert random idle cycles.
// ----------------------------------------------------------------------------
module sorted_array_linked_list_test;

    localparam int SLOTS       = sall_pkg::TABLE_SLOTS_DEF;
    localparam int RANDOM_REQS = 630;
    localparam int POOL_SIZE   = 96;
    localparam int DRAIN_WAIT  = 4 * SLOTS;
    localparam int CYCLE_LIMIT = 600000;

    class list_scoreboard;
        logic [sall_pkg::OUT_SLOT_W-1:0]     link_tbl [SLOTS];
        bit                                  free_tbl [SLOTS];
        logic signed [sall_pkg::VALUE_W-1:0] value_tbl [SLOTS];
        int                                  count;
        sall_pkg::rsp_item_t                 expected_q [$];
        int                                  errors;

        function new();
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int s = 0; s < SLOTS; s++)
            begin
                link_tbl[s]  = '0;
                free_tbl[s]  = (s != 0);
                value_tbl[s] = '0;
            end
            count = 0;
        endfunction

        function void unlink(int prev, int cur);
            link_tbl[prev] = link_tbl[cur];
            link_tbl[cur]  = '0;
            free_tbl[cur]  = 1'b1;
            value_tbl[cur] = '0;
            if (count > 0)
                count--;
        endfunction

        function void note_request(sall_pkg::req_item_t r);
            sall_pkg::rsp_item_t e;
            int                  prev;
            int                  cur;
            int                  steps;
            int                  s;
            e.status = sall_pkg::STATUS_DONE;
            e.slot   = '0;
            prev     = 0;
            cur      = link_tbl[0];
            steps    = 0;
            if (r.req_type == sall_pkg::REQ_INSERT || r.req_type == sall_pkg::REQ_DEL_VALUE)
            begin
                while (cur != 0 && steps < SLOTS && value_tbl[cur] < r.value)
                begin
                    prev = cur;
                    cur  = link_tbl[cur];
                    steps++;
                end
            end
            case (r.req_type)
                sall_pkg::REQ_INSERT:
                begin
                    if (cur != 0 && value_tbl[cur] == r.value)
                        e.status = sall_pkg::STATUS_DUP;
                    else
                    begin
                        s = 1;
                        while (s < SLOTS && !free_tbl[s])
                            s++;
                        if (s >= SLOTS)
                            e.status = sall_pkg::STATUS_FULL;
                        else
                        begin
                            value_tbl[s]   = r.value;
                            link_tbl[s]    = sall_pkg::OUT_SLOT_W'(cur);
                            link_tbl[prev] = sall_pkg::OUT_SLOT_W'(s);
                            free_tbl[s]    = 1'b0;
                            count++;
                            e.slot = sall_pkg::OUT_SLOT_W'(s);
                        end
                    end
                end
                sall_pkg::REQ_DEL_VALUE:
                begin
                    if (cur != 0 && value_tbl[cur] == r.value)
                    begin
                        unlink(prev, cur);
                        e.slot = sall_pkg::OUT_SLOT_W'(cur);
                    end
                    else
                        e.status = sall_pkg::STATUS_NOT_FOUND;
                end
                sall_pkg::REQ_DEL_POS:
                begin
                    if (r.position == 0 || r.position > count)
                        e.status = sall_pkg::STATUS_NOT_FOUND;
                    else
                    begin
                        for (steps = 1; steps < r.position && cur != 0; steps++)
                        begin
                            prev = cur;
                            cur  = link_tbl[cur];
                        end
                        if (cur != 0)
                        begin
                            unlink(prev, cur);
                            e.slot = sall_pkg::OUT_SLOT_W'(cur);
                        end
                        else
                            e.status = sall_pkg::STATUS_NOT_FOUND;
                    end
                end
                default:
                    clear_table();
            endcase
            e.length = sall_pkg::LEN_W'(count);
            expected_q.push_back(e);
        endfunction

        function void check_result(sall_pkg::rsp_item_t got);
            sall_pkg::rsp_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d slot %0d length %0d",
                       got.status, got.slot, got.length);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.slot !== e.slot)
            begin
                $error("slot: expected %0d actual %0d", e.slot, got.slot);
                errors++;
            end
            if (got.length !== e.length)
            begin
                $error("length: expected %0d actual %0d", e.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sall_req_if req_ch ();
    sall_rsp_if rsp_ch ();

    sorted_array_linked_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard                      sb;
    bit                                  no_idle;
    int                                  cycle_count;
    logic signed [sall_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
    logic signed [sall_pkg::VALUE_W-1:0] recent_q [$];

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        no_idle = 1'b0;
        sb = new();
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
        cycle_count = 0;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic signed [sall_pkg::VALUE_W-1:0] pick_value(int full_pct);
        if ($urandom_range(0, 99) < full_pct)
            return $urandom;
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_request(sall_pkg::req_type_t t,
                                logic signed [sall_pkg::VALUE_W-1:0] v,
                                logic [sall_pkg::POS_W-1:0] p);
        int                  gap;
        sall_pkg::req_item_t r;
        gap = draw_gap();
        r.req_type = t;
        r.value    = v;
        r.position = p;
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.payload = r;
        req_ch.valid   = 1'b1;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        sb.note_request(r);
        @(negedge clk);
    endtask

    // result side: random stalls, check at each accepted result
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = draw_gap();
            if (gap > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            sb.check_result(rsp_ch.payload);
        end
    end

    initial
    begin
        int                                  sent;
        int                                  episode;
        int                                  ep_len;
        int                                  mode;
        int                                  roll;
        int                                  clr_pct;
        int                                  ins_pct;
        int                                  dv_pct;
        int                                  full_pct;
        logic signed [sall_pkg::VALUE_W-1:0] v;
        logic [sall_pkg::POS_W-1:0]          p;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // empty list, extremes, duplicates, bad positions, clear
        send_request(sall_pkg::REQ_DEL_VALUE, 32'sd5, 7'h00);
        send_request(sall_pkg::REQ_DEL_POS, 32'sd0, 7'd1);
        send_request(sall_pkg::REQ_INSERT, 32'sd0, 7'h7F);
        send_request(sall_pkg::REQ_INSERT, 32'sh8000_0000, 7'h2A);
        send_request(sall_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 7'h55);
        send_request(sall_pkg::REQ_INSERT, -32'sd1, 7'h00);
        send_request(sall_pkg::REQ_INSERT, 32'sd0, 7'h7F);
        send_request(sall_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 7'h00);
        send_request(sall_pkg::REQ_INSERT, 32'sh8000_0000, 7'h00);
        send_request(sall_pkg::REQ_DEL_POS, 32'sd0, 7'd0);
        send_request(sall_pkg::REQ_DEL_POS, 32'sd0, 7'd5);
        send_request(sall_pkg::REQ_DEL_POS, 32'sh7FFF_FFFF, 7'd127);
        send_request(sall_pkg::REQ_DEL_VALUE, 32'sd7, 7'd1);
        send_request(sall_pkg::REQ_DEL_VALUE, -32'sd1, 7'd0);
        send_request(sall_pkg::REQ_DEL_POS, 32'sd0, 7'd1);
        send_request(sall_pkg::REQ_DEL_POS, 32'sd0, 7'd2);
        send_request(sall_pkg::REQ_INSERT, 32'sh5555_5555, 7'h2A);
        send_request(sall_pkg::REQ_INSERT, 32'shAAAA_AAAA, 7'h55);
        send_request(sall_pkg::REQ_DEL_POS, 32'sd0, 7'd4);
        send_request(sall_pkg::REQ_CLEAR, 32'shFFFF_FFFF, 7'h7F);
        send_request(sall_pkg::REQ_DEL_VALUE, 32'sd0, 7'd0);
        send_request(sall_pkg::REQ_INSERT, 32'sd3, 7'd0);
        send_request(sall_pkg::REQ_DEL_VALUE, 32'sd3, 7'd0);

        sent = 0;
        episode = 0;
        while (sent < RANDOM_REQS)
        begin
            mode = (episode == 0) ? 4 : $urandom_range(0, 3);
            ep_len = (episode == 0) ? 75 : $urandom_range(20, 90);
            no_idle = (mode == 3) || ($urandom_range(0, 5) == 0);
            case (mode)
                0:       begin clr_pct = 0; ins_pct = 85; dv_pct = 8;  full_pct = 70; end
                1:       begin clr_pct = 1; ins_pct = 15; dv_pct = 45; full_pct = 20; end
                4:       begin clr_pct = 0; ins_pct = 100; dv_pct = 0; full_pct = 90; end
                default: begin clr_pct = 2; ins_pct = 45; dv_pct = 30; full_pct = 40; end
            endcase
            if (episode > 0 && $urandom_range(0, 7) == 0)
                send_request(sall_pkg::REQ_CLEAR, $urandom, sall_pkg::POS_W'($urandom));
            for (int i = 0; i < ep_len && sent < RANDOM_REQS; i++)
            begin
                roll = $urandom_range(0, 99);
                p = sall_pkg::POS_W'($urandom);
                if (roll < clr_pct)
                    send_request(sall_pkg::REQ_CLEAR, $urandom, p);
                else if (roll < clr_pct + ins_pct)
                begin
                    v = pick_value(full_pct);
                    recent_q.push_back(v);
                    if (recent_q.size() > SLOTS)
                        void'(recent_q.pop_front());
                    send_request(sall_pkg::REQ_INSERT, v, p);
                end
                else if (roll < clr_pct + ins_pct + dv_pct)
                begin
                    if (recent_q.size() > 0 && $urandom_range(0, 9) < 7)
                        v = recent_q[$urandom_range(0, recent_q.size() - 1)];
                    else
                        v = pick_value(30);
                    send_request(sall_pkg::REQ_DEL_VALUE, v, p);
                end
                else
                begin
                    if ($urandom_range(0, 4) != 0)
                        p = sall_pkg::POS_W'($urandom_range(1, sb.count + 1));
                    send_request(sall_pkg::REQ_DEL_POS, $urandom, p);
                end
                sent++;
            end
            episode++;
        end
        req_ch.valid = 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
